FILE: design/fisqrt_pkg.sv
// ----------------------------------------------------------------------------
// fisqrt_pkg
// Constants and the shared product rounding function for the fast inverse
// square root pipeline.
// ----------------------------------------------------------------------------
package fisqrt_pkg;

  localparam int NSTG = 11;

  localparam logic [31:0] MAGIC_EST  = 32'h5f3759df;
  localparam logic [31:0] QUIET_BIT  = 32'h00400000;
  localparam logic [31:0] POS_INF    = 32'h7f800000;
  localparam logic [31:0] NEG_INF    = 32'hff800000;
  localparam logic [31:0] POS_ZERO   = 32'h00000000;
  localparam logic [28:0] THREE_HALF = 29'h18000000;

  // Rounds a 48-bit significand product whose operands were normalized.
  // The biased exponent es belongs to a product in [1, 2).
  function automatic logic [31:0] round_mul(input logic [47:0] prod,
                                            input logic signed [10:0] es);
    logic signed [10:0] e;
    logic signed [10:0] d;
    logic signed [10:0] ef;
    logic [23:0] m;
    logic        g;
    logic        s;
    logic        up;
    logic [4:0]  sh;
    logic [24:0] wide;
    logic [24:0] shifted;
    logic [24:0] mask;
    logic [24:0] mr;
    logic [22:0] frac;
    logic [31:0] res;
    if (prod[47]) begin
      e = es + 11'sd1;
      m = prod[47:24];
      g = prod[23];
      s = |prod[22:0];
    end else begin
      e = es;
      m = prod[46:23];
      g = prod[22];
      s = |prod[21:0];
    end
    if (e <= 11'sd0) begin
      d       = 11'sd1 - e;
      sh      = (d > 11'sd25) ? 5'd25 : d[4:0];
      wide    = {m, g};
      shifted = wide >> sh;
      mask    = (25'd1 << sh) - 25'd1;
      s       = s | (|(wide & mask));
      m       = shifted[24:1];
      g       = shifted[0];
      e       = 11'sd0;
    end
    up = g & (s | m[0]);
    mr = {1'b0, m} + 25'(up);
    if (e == 11'sd0) begin
      res = {1'b0, 7'd0, mr[23], mr[22:0]};
    end else begin
      ef   = e + $signed({10'd0, mr[24]});
      frac = mr[24] ? mr[23:1] : mr[22:0];
      if (ef >= 11'sd255) begin
        res = POS_INF;
      end else begin
        res = {1'b0, ef[7:0], frac};
      end
    end
    return res;
  endfunction

endpackage

FILE: design/fast_inverse_sqrt_unit.sv
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_unit
// Bit-estimate reciprocal square root with one Newton step, eleven stages.
// ----------------------------------------------------------------------------
// The unit takes one single-precision value per cycle while the output is not
// stalled and returns its approximate reciprocal square root, one result per
// cycle at full rate. Each of the three multiplications has a multiply stage
// and a round stage, and the halving, denormal normalization and subtraction
// have stages of their own. Inputs at or below zero give +0.0, a NaN input
// returns quieted, and +inf gives -inf. A stalled output holds the pipeline
// only as far back as it is full, so empty stages keep taking transfers.
module fast_inverse_sqrt_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_recip_root_bits
);
  import fisqrt_pkg::*;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] spec_r;
  logic [31:0]     spv_r [NSTG];
  logic [31:0]     y_r   [NSTG];

  logic [31:0] b1_r;
  logic        hnorm_r;
  logic [23:0] hm_r;
  logic signed [9:0] he_r;
  logic [23:0] xs_r;
  logic signed [9:0] xe_r;
  logic        xz_r;
  logic [47:0] p4_r;
  logic signed [10:0] es4_r;
  logic        z4_r;
  logic [31:0] t1_r;
  logic [47:0] p6_r;
  logic signed [10:0] es6_r;
  logic        z6_r;
  logic [31:0] t2_r;
  logic [28:0] r8_r;
  logic [23:0] t3s_r;
  logic [7:0]  t3e_r;
  logic [47:0] p10_r;
  logic signed [10:0] es10_r;
  logic [31:0] out_r;

  logic        spec_nxt;
  logic [31:0] spv_nxt;
  logic [31:0] y_nxt;
  logic        hnorm_nxt;
  logic [23:0] hm_nxt;
  logic signed [9:0] he_nxt;
  logic [23:0] sigv;
  logic [4:0]  lz;
  logic [23:0] xs_nxt;
  logic signed [9:0] xe_nxt;
  logic [23:0] t2sig;
  logic [7:0]  t2e;
  logic [7:0]  nsh;
  logic [4:0]  nc;
  logic [28:0] tfix;
  logic [23:0] smask;
  logic [28:0] r8_nxt;
  logic [23:0] rm;
  logic        rg;
  logic        rs;
  logic        rup;
  logic [24:0] rmr;
  logic [23:0] t3s_nxt;
  logic [7:0]  t3e_nxt;
  logic [7:0]  rexp;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall            = !en[0];
  assign out_valid           = vld_r[NSTG-1];
  assign out_recip_root_bits = out_r;

  always_comb begin
    spec_nxt = 1'b0;
    spv_nxt  = POS_ZERO;
    if ((b1_r[30:23] == 8'hff) && (b1_r[22:0] != 23'd0)) begin
      spec_nxt = 1'b1;
      spv_nxt  = b1_r | QUIET_BIT;
    end else if (b1_r[31] || (b1_r == POS_ZERO)) begin
      spec_nxt = 1'b1;
    end else if (b1_r == POS_INF) begin
      spec_nxt = 1'b1;
      spv_nxt  = NEG_INF;
    end
    y_nxt = MAGIC_EST - {1'b0, b1_r[31:1]};
    sigv  = {(b1_r[30:23] == 8'd1), b1_r[22:0]};
    if (b1_r[30:23] >= 8'd2) begin
      hnorm_nxt = 1'b1;
      hm_nxt    = {1'b1, b1_r[22:0]};
      he_nxt    = $signed({2'b00, b1_r[30:23]}) - 10'sd1;
    end else begin
      hnorm_nxt = 1'b0;
      hm_nxt    = {1'b0, sigv[23:1]} + 24'(sigv[0] & sigv[1]);
      he_nxt    = 10'sd0;
    end
  end

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (hm_r[i]) begin
        lz = 5'(23 - i);
      end
    end
    if (hnorm_r) begin
      xs_nxt = hm_r;
      xe_nxt = he_r;
    end else begin
      xs_nxt = hm_r << lz;
      xe_nxt = 10'sd1 - $signed({5'd0, lz});
    end
  end

  always_comb begin
    t2e   = t2_r[30:23];
    t2sig = {(t2e != 8'd0), t2_r[22:0]};
    nsh   = 8'd0;
    nc    = 5'd0;
    smask = 24'd0;
    if (t2e >= 8'd122) begin
      tfix = 29'(t2sig) << 3'(t2e - 8'd122);
    end else begin
      nsh   = 8'd122 - t2e;
      nc    = (nsh > 8'd31) ? 5'd31 : nsh[4:0];
      smask = (24'd1 << nc) - 24'd1;
      tfix  = (29'(t2sig) >> nc) | 29'(|(t2sig & smask));
    end
    r8_nxt = THREE_HALF - tfix;
  end

  always_comb begin
    if (r8_r[28]) begin
      rm   = r8_r[28:5];
      rg   = r8_r[4];
      rs   = |r8_r[3:0];
      rexp = 8'd127;
    end else begin
      rm   = r8_r[27:4];
      rg   = r8_r[3];
      rs   = |r8_r[2:0];
      rexp = 8'd126;
    end
    rup = rg & (rs | rm[0]);
    rmr = {1'b0, rm} + 25'(rup);
    if (rmr[24]) begin
      t3s_nxt = 24'h800000;
      t3e_nxt = rexp + 8'd1;
    end else begin
      t3s_nxt = rmr[23:0];
      t3e_nxt = rexp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      b1_r <= in_operand_bits;
    end
    if (en[1]) begin
      spec_r[1] <= spec_nxt;
      spv_r[1]  <= spv_nxt;
      y_r[1]    <= y_nxt;
      hnorm_r   <= hnorm_nxt;
      hm_r      <= hm_nxt;
      he_r      <= he_nxt;
    end
    for (int k = 2; k < NSTG; k++) begin
      if (en[k]) begin
        spec_r[k] <= spec_r[k-1];
        spv_r[k]  <= spv_r[k-1];
        y_r[k]    <= y_r[k-1];
      end
    end
    if (en[2]) begin
      xs_r <= xs_nxt;
      xe_r <= xe_nxt;
      xz_r <= (hm_r == 24'd0);
    end
    if (en[3]) begin
      p4_r  <= 48'(xs_r) * 48'({1'b1, y_r[2][22:0]});
      es4_r <= $signed({xe_r[9], xe_r}) + $signed({3'b000, y_r[2][30:23]}) - 11'sd127;
      z4_r  <= xz_r;
    end
    if (en[4]) begin
      t1_r <= z4_r ? POS_ZERO : round_mul(p4_r, es4_r);
    end
    if (en[5]) begin
      p6_r  <= 48'({1'b1, t1_r[22:0]}) * 48'({1'b1, y_r[4][22:0]});
      es6_r <= $signed({3'b000, t1_r[30:23]}) + $signed({3'b000, y_r[4][30:23]})
               - 11'sd127;
      z6_r  <= (t1_r[30:23] == 8'd0);
    end
    if (en[6]) begin
      t2_r <= z6_r ? POS_ZERO : round_mul(p6_r, es6_r);
    end
    if (en[7]) begin
      r8_r <= r8_nxt;
    end
    if (en[8]) begin
      t3s_r <= t3s_nxt;
      t3e_r <= t3e_nxt;
    end
    if (en[9]) begin
      p10_r  <= 48'(t3s_r) * 48'({1'b1, y_r[8][22:0]});
      es10_r <= $signed({3'b000, t3e_r}) + $signed({3'b000, y_r[8][30:23]}) - 11'sd127;
    end
    if (en[10]) begin
      out_r <= spec_r[9] ? spv_r[9] : round_mul(p10_r, es10_r);
    end
  end

  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output side is free");

  a_free_flow : assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with no output stall");

  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && en[2]) |=> vld_r[2])
    else $error("item lost between stages");

endmodule
